/* rtl/core/assert_macros.svh */
// Assertion macros for the RTL (included by copf_dpath). Compiled out when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

/* rtl/core/copf_pkg.sv */
package copf_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // APB map: one 32-bit register per word
    localparam int          APB_ADDR_W    = 3;
    localparam logic [0:0]  REG_HEARTBEAT = 1'b0;

    typedef enum logic [1:0] {
        ACT_INT   = 2'd0,
        ACT_BYTE  = 2'd1,
        ACT_FORCE = 2'd2,
        ACT_EMPTY = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_INT   = 2'd1,
        KIND_STR   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        REASON_NONE      = 3'd0,
        REASON_STALE     = 3'd1,
        REASON_FIRST     = 3'd2,
        REASON_CHANGED   = 3'd3,
        REASON_HEARTBEAT = 3'd4
    } reason_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_CHECK = 1'b1
    } state_t;

    typedef struct packed {
        kind_t       kind;
        logic [31:0] ival;
        logic [15:0] hash;
        logic [31:0] stamp;
    } entry_t;

    // controller -> datapath
    typedef struct packed {
        logic load;        // latch item, issue slot read
        logic load_str;    // item is a string check
        logic crc_step;    // fold text byte into running CRC
        logic crc_clear;   // running CRC back to init
        logic force_stale; // mark every slot stale
        logic commit;      // decide, write back, post result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic out_free;    // result register can take a new transfer
    } sts_t;

    // CRC16, MSB first, one byte
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/copf_ram.sv */
module copf_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/copf_ctrl.sv */
module copf_ctrl
    import copf_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_tvalid,
    input  action_t action,
    input  logic    last_byte,
    input  sts_t    sts,
    output logic    s_tready,
    output cmd_t    cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    case (action)
                        ACT_INT:   state_next = ST_CHECK;
                        ACT_EMPTY: state_next = ST_CHECK;
                        ACT_BYTE:  state_next = last_byte ? ST_CHECK : ST_IDLE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CHECK: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_tready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    case (action)
                        ACT_INT: begin
                            cmd.load = 1'b1;
                        end
                        ACT_BYTE: begin
                            cmd.crc_step = 1'b1;
                            if (last_byte) begin
                                cmd.load      = 1'b1;
                                cmd.load_str  = 1'b1;
                                cmd.crc_clear = 1'b1;
                            end
                        end
                        ACT_FORCE: begin
                            cmd.force_stale = 1'b1;
                        end
                        default: begin
                            cmd.load      = 1'b1;
                            cmd.load_str  = 1'b1;
                            cmd.crc_clear = 1'b1;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                cmd.commit = sts.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/core/copf_dpath.sv */
`include "assert_macros.svh"

module copf_dpath
    import copf_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic [7:0]  slot,
    input  logic [31:0] int_value,
    input  logic [7:0]  text_byte,
    input  logic [31:0] now_seconds,
    input  logic [15:0] heartbeat,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic        publish,
    output reason_t     reason
);

    // item held across the check
    logic [7:0]  slot_reg;
    logic        is_str_reg;
    logic [31:0] ival_reg;
    logic [15:0] hash_reg;
    logic [31:0] now_reg;
    logic [15:0] crc_reg;
    logic [15:0] crc_after;

    logic [SLOT_COUNT-1:0] valid_reg;
    logic [SLOT_COUNT-1:0] stale_reg;

    logic        m_tvalid_reg;
    logic        publish_reg;
    reason_t     reason_reg;

    logic [$bits(entry_t)-1:0] ram_rdata;
    logic [$bits(entry_t)-1:0] ram_wdata;
    logic                      ram_we;

    logic [SLOT_W-1:0] idx;
    logic              in_range;
    entry_t            cur;
    entry_t            upd;
    logic [31:0]       age;
    reason_t           why;

    assign crc_after = crc_byte(crc_reg, text_byte);
    assign idx       = slot_reg[SLOT_W-1:0];
    assign in_range  = {1'b0, slot_reg} < 9'(SLOT_COUNT);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            slot_reg   <= slot;
            is_str_reg <= cmd.load_str;
            ival_reg   <= int_value;
            hash_reg   <= cmd.crc_step ? crc_after : CRC_INIT;
            now_reg    <= now_seconds;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
        end else if (cmd.crc_clear) begin
            crc_reg <= CRC_INIT;
        end else if (cmd.crc_step) begin
            crc_reg <= crc_after;
        end
    end

    copf_ram #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx),
        .wdata (ram_wdata),
        .re    (cmd.load),
        .raddr (slot[SLOT_W-1:0]),
        .rdata (ram_rdata)
    );

    // unwritten slots read as empty
    always_comb begin
        cur = valid_reg[idx] ? entry_t'(ram_rdata) : '0;
        age = now_reg - cur.stamp;
        upd = cur;
        why = REASON_NONE;
        if (!in_range) begin
            why = REASON_NONE;
        end else if (stale_reg[idx]) begin
            why = REASON_STALE;
        end else if (cur.kind == KIND_EMPTY) begin
            why = REASON_FIRST;
        end else if (is_str_reg ? (cur.hash != hash_reg) : (cur.ival != ival_reg)) begin
            why = REASON_CHANGED;
        end else if (heartbeat != 16'd0 && age >= {16'd0, heartbeat}) begin
            why = REASON_HEARTBEAT;
        end
        upd.stamp = now_reg;
        if (why != REASON_HEARTBEAT) begin
            if (is_str_reg) begin
                upd.kind = KIND_STR;
                upd.hash = hash_reg;
            end else begin
                upd.kind = KIND_INT;
                upd.ival = ival_reg;
            end
        end
    end

    assign ram_we    = cmd.commit && (why != REASON_NONE);
    assign ram_wdata = upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            stale_reg <= '0;
        end else begin
            if (cmd.force_stale) begin
                stale_reg <= '1;
            end
            if (ram_we) begin
                valid_reg[idx] <= 1'b1;
                stale_reg[idx] <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            publish_reg <= (why != REASON_NONE);
            reason_reg  <= why;
        end
    end

    assign sts.out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign publish      = publish_reg;
    assign reason       = reason_reg;

    `ASSERT_AT(a_commit_room, aclk, aresetn, cmd.commit |-> (!m_tvalid_reg || m_tready))
    `ASSERT_AT(a_pub_reason, aclk, aresetn, m_tvalid_reg |-> (publish_reg == (reason_reg != REASON_NONE)))
    `ASSERT_AT(a_force_all, aclk, aresetn, cmd.force_stale |=> (&stale_reg))
    `ASSERT_NEVER(a_write_range, aclk, aresetn, ram_we && !in_range)

endmodule

/* rtl/core/change_only_publish_filter.sv */
// Change-only publish filter. Each check names a slot and presents either a
// 32-bit integer or a string, streamed in one byte per transfer and folded
// into a CRC16 (poly 0x1021, init 0xFFFF, MSB first). The block answers with
// one result transfer per completed check: publish set, with a reason, when
// the slot is stale, empty, holds a different value or hash, or when the
// heartbeat interval has run out since the last publish; otherwise publish
// clear with reason none. Slots at or above the slot count always answer
// "no publish" and are never touched. A force-all transfer marks every slot
// stale and, like a non-final string byte, produces no result.
// Sequence: a check is accepted and the slot memory read in state IDLE, then
// compared and written back in state CHECK; a non-final string byte or
// force-all finishes in IDLE. The read-modify-write of the slot memory
// (registered read, then write back) sets this order.
// A result waits in an output register, and the next transfer is taken while
// it waits; a check only stalls in CHECK while that register is still full
// and m_tready is low. Reset clears the slot table at once through per-slot
// valid and stale bits: there is no clearing pass.
// heartbeat_seconds lives at APB byte address 0; zero turns the heartbeat off.
// Write it only while no check is in flight.

module change_only_publish_filter
    import copf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [79:0]           s_tdata,  // slot[7:0], int_value[39:8],
                                            // text_byte[47:40], now_seconds[79:48]
    input  logic [1:0]            s_tuser,  // action[1:0]
    input  logic                  s_tlast,  // last_byte

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,  // publish[0], reason[3:1], zero[7:4]

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    cmd_t        cmd;
    sts_t        sts;
    logic [15:0] heartbeat_reg;
    logic        hb_sel;
    logic        publish;
    reason_t     reason;

    // Register map decode: word index from the upper address bits
    assign hb_sel = (paddr[APB_ADDR_W-1:2] == REG_HEARTBEAT);
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heartbeat_reg <= 16'd0;
        end else if (psel && penable && pwrite && pready && hb_sel) begin
            heartbeat_reg <= pwdata[15:0];
        end
    end

    assign prdata = hb_sel ? {16'd0, heartbeat_reg} : 32'd0;

    // Sequencer: decides per transfer what the datapath does
    copf_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .action    (action_t'(s_tuser)),
        .last_byte (s_tlast),
        .sts       (sts),
        .s_tready  (s_tready),
        .cmd       (cmd)
    );

    // CRC, slot table and the compare/update logic
    copf_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .slot        (s_tdata[7:0]),
        .int_value   (s_tdata[39:8]),
        .text_byte   (s_tdata[47:40]),
        .now_seconds (s_tdata[79:48]),
        .heartbeat   (heartbeat_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .publish     (publish),
        .reason      (reason)
    );

    assign m_tdata = {4'd0, reason, publish};

endmodule
